[design/cfbs_pkg.sv]
package cfbs_pkg;

  // Kind of result word.
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // Number of the bus access in flight; idle when none.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_1    = 3'd1,
    PH_2    = 3'd2,
    PH_3    = 3'd3,
    PH_4    = 3'd4,
    PH_5    = 3'd5,
    PH_6    = 3'd6
  } phase_e;

  // Instruction codes; codes below INS_BRK are the eight conditional branches.
  localparam logic [3:0] INS_BRK     = 4'd8;
  localparam logic [3:0] INS_JMP_ABS = 4'd9;
  localparam logic [3:0] INS_JMP_IND = 4'd10;
  localparam logic [3:0] INS_JSR     = 4'd11;
  localparam logic [3:0] INS_RTI     = 4'd12;
  localparam logic [3:0] INS_RTS     = 4'd13;

  // Branch condition codes, taken from the low three bits of the instruction.
  localparam logic [2:0] BR_CC = 3'd0;
  localparam logic [2:0] BR_CS = 3'd1;
  localparam logic [2:0] BR_EQ = 3'd2;
  localparam logic [2:0] BR_MI = 3'd3;
  localparam logic [2:0] BR_NE = 3'd4;
  localparam logic [2:0] BR_PL = 3'd5;
  localparam logic [2:0] BR_VC = 3'd6;
  localparam logic [2:0] BR_VS = 3'd7;

  // Status bits.
  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_U = 8'h20;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;

  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] VEC_BRK_LO = 16'hFFFE;
  localparam logic [15:0] VEC_BRK_HI = 16'hFFFF;
  localparam logic        ACT_START  = 1'b0;

  typedef struct packed {
    logic       action;
    logic [3:0] instruction;
    logic [15:0] pc_in;
    logic [7:0] sp_in;
    logic [7:0] flags_in;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] pc_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  op_kind;
    logic [15:0] pc;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [7:0]  low_byte;
    logic [15:0] ptr_addr;
    logic [15:0] br_target;
  } seq_state_t;

endpackage

[design/cfbs_if.sv]
interface cfbs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  instruction;
  logic [15:0] pc_in;
  logic [7:0]  sp_in;
  logic [7:0]  flags_in;
  logic [7:0]  read_data;

  modport source (
    output valid, action, instruction, pc_in, sp_in, flags_in, read_data,
    input  ready
  );
  modport sink (
    input  valid, action, instruction, pc_in, sp_in, flags_in, read_data,
    output ready
  );
endinterface

interface cfbs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [15:0] pc_out;
  logic [7:0]  sp_out;
  logic [7:0]  flags_out;

  modport source (
    output valid, kind, address, write_data, pc_out, sp_out, flags_out,
    input  ready
  );
  modport sink (
    input  valid, kind, address, write_data, pc_out, sp_out, flags_out,
    output ready
  );
endinterface

[design/cpu_control_flow_bus_sequencer_top.sv]
// Bus-cycle sequencer for the control-flow instructions of a 6502 core.
//
// The input channel takes one word per bus cycle of the emulated CPU. A start
// word names the instruction and loads the program counter (just past the
// opcode), the stack pointer and the status byte. Each later word reports
// that the previous bus access has completed and carries its read byte.
// Every accepted word yields exactly one result word on the output channel:
// a read request, a write request with its data, or a done word carrying the
// new program counter, stack pointer and status byte.
//
// Each accepted word's result is registered in the output stage, or in the
// skid stage while the output stalls. One word per cycle is sustained while
// the receiver takes results, set by the single pass through the sequencing
// logic between the state register and the output register. A second output
// stage holds one result while the receiver stalls, so the input still takes
// one further word, then holds ready low until the receiver drains the output.
//
// Reset clears the sequencer state to idle with all state fields zero and
// empties both output stages.
module cpu_control_flow_bus_sequencer_top import cfbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfbs_in_if.sink    in_i,
  cfbs_out_if.source res_o
);

  seq_state_t st_q, st_d;
  in_item_t   item;
  res_t       res_d;
  res_t       out_q;
  res_t       skid_q;
  logic       out_valid_q;
  logic       skid_valid_q;
  logic       in_fire;
  logic       out_fire;
  logic       out_free;

  assign item = '{
    action:      in_i.action,
    instruction: in_i.instruction,
    pc_in:       in_i.pc_in,
    sp_in:       in_i.sp_in,
    flags_in:    in_i.flags_in,
    read_data:   in_i.read_data
  };

  cfbs_step u_step (
    .st_i   (st_q),
    .item_i (item),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // The skid stage fills only when the output stage is busy and stalled.
  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && res_o.ready;
  assign out_free   = !out_valid_q || out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      if (skid_valid_q) begin
        if (out_free) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload stages carry no reset.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = out_q.kind;
  assign res_o.address    = out_q.address;
  assign res_o.write_data = out_q.write_data;
  assign res_o.pc_out     = out_q.pc_out;
  assign res_o.sp_out     = out_q.sp_out;
  assign res_o.flags_out  = out_q.flags_out;

  // A held result in the skid stage always sits behind a full output stage.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output stage empty");

  // A word accepted against a stalled output must land in the skid stage.
  a_stall_to_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && !res_o.ready) |=> skid_valid_q)
    else $error("result lost on a stalled output");

  // A done result leaves the sequencer idle.
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.kind == KIND_DONE) |=> st_q.phase == PH_IDLE)
    else $error("sequencer busy after a done result");

  // A bus request always leaves an access in flight.
  a_req_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res_d.kind != KIND_DONE) |=> st_q.phase != PH_IDLE)
    else $error("sequencer idle after a bus request");

endmodule

[design/cfbs_step.sv]
module cfbs_step import cfbs_pkg::*; (
  input  seq_state_t st_i,
  input  in_item_t   item_i,
  output seq_state_t st_o,
  output res_t       res_o
);

  function automatic logic branch_taken(input logic [2:0] cc, input logic [7:0] f);
    logic t;
    unique case (cc)
      BR_CC:   t = (f & FLAG_C) == 8'h00;
      BR_CS:   t = (f & FLAG_C) != 8'h00;
      BR_EQ:   t = (f & FLAG_Z) != 8'h00;
      BR_MI:   t = (f & FLAG_N) != 8'h00;
      BR_NE:   t = (f & FLAG_Z) == 8'h00;
      BR_PL:   t = (f & FLAG_N) == 8'h00;
      BR_VC:   t = (f & FLAG_V) == 8'h00;
      BR_VS:   t = (f & FLAG_V) != 8'h00;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

  seq_state_t  nx;
  res_t        r;
  logic        done;
  logic [7:0]  d;
  logic [15:0] pc1;
  logic [15:0] sa;
  logic [15:0] sa_up;
  logic [7:0]  sp_up;
  logic [7:0]  sp_dn;
  logic [15:0] offs;
  logic [15:0] pull_pc;
  logic        is_rti;

  always_comb begin
    nx      = st_i;
    r       = '0;
    r.kind  = KIND_DONE;
    done    = 1'b0;
    d       = item_i.read_data;
    pc1     = st_i.pc + 16'd1;
    sa      = {STACK_PAGE, st_i.sp};
    sp_up   = st_i.sp + 8'd1;
    sp_dn   = st_i.sp - 8'd1;
    sa_up   = {STACK_PAGE, sp_up};
    offs    = {{8{d[7]}}, d};
    pull_pc = {d, st_i.low_byte};
    is_rti  = (st_i.op_kind == INS_RTI);

    if (item_i.action == ACT_START) begin
      nx.op_kind = item_i.instruction;
      nx.pc      = item_i.pc_in;
      nx.sp      = item_i.sp_in;
      nx.flags   = item_i.flags_in;
      if (item_i.instruction > INS_RTS) begin
        done = 1'b1;
      end else begin
        nx.phase  = PH_1;
        r.kind    = KIND_READ;
        r.address = item_i.pc_in;
      end
    end else if (st_i.phase == PH_IDLE) begin
      done = 1'b1;
    end else if (!st_i.op_kind[3]) begin
      // Conditional branch: operand, optional target fix-up, optional page fix-up.
      unique case (st_i.phase)
        PH_1: begin
          nx.pc = pc1;
          if (!branch_taken(st_i.op_kind[2:0], st_i.flags)) begin
            done = 1'b1;
          end else begin
            nx.br_target = pc1 + offs;
            nx.phase     = PH_2;
            r.kind       = KIND_READ;
            r.address    = pc1;
          end
        end
        PH_2: begin
          if (st_i.br_target[15:8] != st_i.pc[15:8]) begin
            nx.phase  = PH_3;
            r.kind    = KIND_READ;
            r.address = {st_i.pc[15:8], st_i.br_target[7:0]};
          end else begin
            nx.pc = st_i.br_target;
            done  = 1'b1;
          end
        end
        PH_3: begin
          nx.pc = st_i.br_target;
          done  = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end else begin
      unique case (st_i.op_kind)
        INS_BRK: begin
          unique case (st_i.phase)
            PH_1: begin
              nx.pc        = pc1;
              nx.phase     = PH_2;
              nx.sp        = sp_dn;
              r.kind       = KIND_WRITE;
              r.address    = sa;
              r.write_data = pc1[15:8];
            end
            PH_2: begin
              nx.phase     = PH_3;
              nx.sp        = sp_dn;
              r.kind       = KIND_WRITE;
              r.address    = sa;
              r.write_data = st_i.pc[7:0];
            end
            PH_3: begin
              nx.phase     = PH_4;
              nx.sp        = sp_dn;
              nx.flags     = st_i.flags | FLAG_I;
              r.kind       = KIND_WRITE;
              r.address    = sa;
              r.write_data = st_i.flags | FLAG_B | FLAG_U;
            end
            PH_4: begin
              nx.phase  = PH_5;
              r.kind    = KIND_READ;
              r.address = VEC_BRK_LO;
            end
            PH_5: begin
              nx.low_byte = d;
              nx.phase    = PH_6;
              r.kind      = KIND_READ;
              r.address   = VEC_BRK_HI;
            end
            PH_6: begin
              nx.pc = pull_pc;
              done  = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        INS_JMP_ABS, INS_JMP_IND: begin
          unique case (st_i.phase)
            PH_1: begin
              nx.low_byte = d;
              nx.pc       = pc1;
              nx.phase    = PH_2;
              r.kind      = KIND_READ;
              r.address   = pc1;
            end
            PH_2: begin
              if (st_i.op_kind == INS_JMP_ABS) begin
                nx.pc = pull_pc;
                done  = 1'b1;
              end else begin
                nx.pc       = pc1;
                nx.ptr_addr = pull_pc;
                nx.phase    = PH_3;
                r.kind      = KIND_READ;
                r.address   = pull_pc;
              end
            end
            PH_3: begin
              if (st_i.op_kind != INS_JMP_IND) begin
                done = 1'b1;
              end else begin
                // The high byte comes from the same page as the pointer.
                nx.low_byte = d;
                nx.phase    = PH_4;
                r.kind      = KIND_READ;
                r.address   = {st_i.ptr_addr[15:8], st_i.ptr_addr[7:0] + 8'd1};
              end
            end
            PH_4: begin
              if (st_i.op_kind == INS_JMP_IND) begin
                nx.pc = pull_pc;
              end
              done = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        INS_JSR: begin
          unique case (st_i.phase)
            PH_1: begin
              nx.low_byte = d;
              nx.pc       = pc1;
              nx.phase    = PH_2;
              r.kind      = KIND_READ;
              r.address   = sa;
            end
            PH_2: begin
              nx.phase     = PH_3;
              nx.sp        = sp_dn;
              r.kind       = KIND_WRITE;
              r.address    = sa;
              r.write_data = st_i.pc[15:8];
            end
            PH_3: begin
              nx.phase     = PH_4;
              nx.sp        = sp_dn;
              r.kind       = KIND_WRITE;
              r.address    = sa;
              r.write_data = st_i.pc[7:0];
            end
            PH_4: begin
              nx.phase  = PH_5;
              r.kind    = KIND_READ;
              r.address = st_i.pc;
            end
            PH_5: begin
              nx.pc = pull_pc;
              done  = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        INS_RTI, INS_RTS: begin
          unique case (st_i.phase)
            PH_1: begin
              nx.phase  = PH_2;
              r.kind    = KIND_READ;
              r.address = sa;
            end
            PH_2: begin
              nx.sp     = sp_up;
              nx.phase  = PH_3;
              r.kind    = KIND_READ;
              r.address = sa_up;
            end
            PH_3: begin
              if (is_rti) begin
                nx.flags = d | FLAG_U;
              end else begin
                nx.low_byte = d;
              end
              nx.sp     = sp_up;
              nx.phase  = PH_4;
              r.kind    = KIND_READ;
              r.address = sa_up;
            end
            PH_4: begin
              nx.phase = PH_5;
              r.kind   = KIND_READ;
              if (is_rti) begin
                nx.low_byte = d;
                nx.sp       = sp_up;
                r.address   = sa_up;
              end else begin
                nx.pc     = pull_pc;
                r.address = pull_pc;
              end
            end
            PH_5: begin
              nx.pc = is_rti ? pull_pc : pc1;
              done  = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      nx.phase     = PH_IDLE;
      r.kind       = KIND_DONE;
      r.address    = '0;
      r.write_data = '0;
      r.pc_out     = nx.pc;
      r.sp_out     = nx.sp;
      r.flags_out  = nx.flags;
    end
  end

  assign st_o  = nx;
  assign res_o = r;

endmodule
